// File: hw/rtl/sdl_pkg.sv
package sdl_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_GDT_BASE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GDT_LIMIT = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LDT_BASE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_LDT_LIMIT = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PROT_NOT_V86 = 3'd4;

   localparam logic [1:0] ACTION_RAW = 2'd0;
   localparam logic [1:0] ACTION_DATA = 2'd1;
   localparam logic [1:0] ACTION_STACK = 2'd2;
   localparam logic [1:0] ACTION_CODE = 2'd3;

   localparam logic [2:0] FAULT_NONE = 3'd0;
   localparam logic [2:0] FAULT_GP = 3'd1;
   localparam logic [2:0] FAULT_NP = 3'd2;
   localparam logic [2:0] FAULT_SS = 3'd3;
   localparam logic [2:0] FAULT_UNKNOWN = 3'd4;

   localparam int unsigned AccPresent = 7;
   localparam int unsigned AccCodeData = 4;
   localparam int unsigned AccExec = 3;
   localparam int unsigned AccExDown = 2;
   localparam int unsigned AccReadable = 1;
   localparam int unsigned AccAccessed = 0;
   localparam int unsigned FlgGran = 3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] selector;
      logic [63:0] descriptor;
   } req_type;

   typedef struct packed {
      logic [2:0]  fault;
      logic [15:0] error_code;
      logic [31:0] table_address;
      logic        write_access_back;
      logic [7:0]  access_byte;
      logic [3:0]  flags_nibble;
      logic [31:0] seg_base;
      logic [19:0] raw_limit;
      logic [31:0] offset_low;
      logic [31:0] offset_high;
      logic [1:0]  dpl;
      logic [1:0]  current_cpl;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  fault;
      logic [15:0] error_code;
      logic        wb;
      logic [7:0]  acc;
      logic [3:0]  flg;
      logic [31:0] base;
      logic [19:0] lim;
      logic        calc_en;
      logic        exdown;
      logic        gran;
      logic        cpl_load;
      logic [1:0]  rpl;
   } dec_type;

endpackage

// File: hw/rtl/sdl_decode.sv
module sdl_decode (
   input  logic [1:0]      action,
   input  logic [15:0]     selector,
   input  logic [63:0]     descriptor,
   input  logic            limit_fail,
   output sdl_pkg::dec_type dec
);
   import sdl_pkg::*;

   logic       nonnull;
   logic [7:0] acc_raw;
   logic       present;
   logic       wb;
   logic       abort;
   logic [2:0] fault;
   logic       calc_en;
   logic       exdown;
   logic       cpl_load;
   logic       code_ok;

   assign nonnull = (selector[15:2] != 14'd0);
   assign acc_raw = nonnull ? descriptor[47:40] : 8'd0;
   assign present = acc_raw[AccPresent];
   assign wb = nonnull && acc_raw[AccCodeData] && acc_raw[AccPresent] && !acc_raw[AccAccessed];
   assign code_ok = acc_raw[AccPresent] && acc_raw[AccCodeData] && acc_raw[AccExec] &&
                    acc_raw[AccReadable];

   always_comb begin
      fault = FAULT_NONE;
      abort = 1'b0;
      calc_en = 1'b0;
      exdown = 1'b0;
      cpl_load = 1'b0;
      priority if (limit_fail) begin
         fault = FAULT_GP;
         abort = 1'b1;
      end else if (action == ACTION_DATA && nonnull && !present) begin
         fault = FAULT_NP;
         abort = 1'b1;
      end else if (action == ACTION_STACK && !present) begin
         fault = FAULT_SS;
         abort = 1'b1;
      end else if (action == ACTION_CODE) begin
         fault = code_ok ? FAULT_NONE : FAULT_UNKNOWN;
         calc_en = 1'b1;
         cpl_load = 1'b1;
      end else if (action == ACTION_DATA || action == ACTION_STACK) begin
         calc_en = 1'b1;
         exdown = acc_raw[AccExDown];
      end else begin
         calc_en = 1'b0;
      end
   end

   always_comb begin
      dec = '0;
      dec.fault = fault;
      dec.error_code = (fault != FAULT_NONE) ? {selector[15:2], 2'b00} : 16'd0;
      dec.rpl = selector[1:0];
      if (!abort) begin
         dec.wb = wb;
         dec.acc = acc_raw | {7'd0, wb};
         dec.flg = nonnull ? descriptor[55:52] : 4'd0;
         dec.base = nonnull ? {descriptor[63:56], descriptor[39:16]} : 32'd0;
         dec.lim = nonnull ? {descriptor[51:48], descriptor[15:0]} : 20'd0;
         dec.calc_en = calc_en;
         dec.exdown = exdown;
         dec.gran = nonnull ? descriptor[52 + FlgGran] : 1'b0;
         dec.cpl_load = cpl_load;
      end
   end

endmodule

// File: hw/rtl/segment_descriptor_loader.sv
// Throughput: one transaction per cycle; a three-stage pipeline (table check,
// descriptor decode, offset range and privilege update) with per-stage stall.
// Reset clears the configuration registers, the privilege level and all
// pipeline valid bits.
module segment_descriptor_loader (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  sdl_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output sdl_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write_en,
   input  logic [sdl_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [sdl_pkg::CsrDataWidth-1:0]       csr_wdata
);
   import sdl_pkg::*;

   logic [31:0] gdt_base_ff;
   logic [15:0] gdt_limit_ff;
   logic [31:0] ldt_base_ff;
   logic [19:0] ldt_limit_ff;
   logic        pnv_ff;
   logic [1:0]  priv_ff;
   logic [1:0]  priv_in;

   logic        s1_valid_ff;
   req_type     s1_req_ff;
   logic [31:0] s1_taddr_ff;
   logic        s1_fail_ff;
   logic        s2_valid_ff;
   dec_type     s2_dec_ff;
   logic [31:0] s2_taddr_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic        s1_rdy;
   logic        s2_rdy;
   logic        s3_rdy;
   logic [31:0] tbase;
   logic [19:0] tlim;
   logic [19:0] body_end;
   logic        fail_in;
   logic [31:0] taddr_in;
   dec_type     dec_in;
   logic [20:0] lim_inc;
   logic [31:0] lim_inc_page;

   always_ff @(posedge clock) begin
      if (reset) begin
         gdt_base_ff <= '0;
         gdt_limit_ff <= '0;
         ldt_base_ff <= '0;
         ldt_limit_ff <= '0;
         pnv_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GDT_BASE: gdt_base_ff <= csr_wdata;
            CSR_GDT_LIMIT: gdt_limit_ff <= csr_wdata[15:0];
            CSR_LDT_BASE: ldt_base_ff <= csr_wdata;
            CSR_LDT_LIMIT: ldt_limit_ff <= csr_wdata[19:0];
            CSR_PROT_NOT_V86: pnv_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign s3_rdy = !rsp_valid_ff || rsp_ready;
   assign s2_rdy = !s2_valid_ff || s3_rdy;
   assign s1_rdy = !s1_valid_ff || s2_rdy;
   assign req_ready = s1_rdy;

   assign tbase = req_data.selector[2] ? ldt_base_ff : gdt_base_ff;
   assign tlim = req_data.selector[2] ? ldt_limit_ff : {4'd0, gdt_limit_ff};
   assign body_end = {4'd0, req_data.selector[15:3], 3'b111};
   assign fail_in = body_end > tlim;
   assign taddr_in = tbase + {16'd0, req_data.selector[15:3], 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_req_ff <= req_data;
         s1_taddr_ff <= taddr_in;
         s1_fail_ff <= fail_in;
      end
   end

   sdl_decode u_decode (
      .action     (s1_req_ff.action),
      .selector   (s1_req_ff.selector),
      .descriptor (s1_req_ff.descriptor),
      .limit_fail (s1_fail_ff),
      .dec        (dec_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_dec_ff <= dec_in;
         s2_taddr_ff <= s1_taddr_ff;
      end
   end

   assign lim_inc = {1'b0, s2_dec_ff.lim} + 21'd1;
   assign lim_inc_page = {lim_inc[19:0], 12'd0};
   assign priv_in = (s2_dec_ff.cpl_load && pnv_ff) ? s2_dec_ff.rpl : priv_ff;

   always_comb begin
      rsp_in = '0;
      rsp_in.fault = s2_dec_ff.fault;
      rsp_in.error_code = s2_dec_ff.error_code;
      rsp_in.table_address = s2_taddr_ff;
      rsp_in.write_access_back = s2_dec_ff.wb;
      rsp_in.access_byte = s2_dec_ff.acc;
      rsp_in.flags_nibble = s2_dec_ff.flg;
      rsp_in.seg_base = s2_dec_ff.base;
      rsp_in.raw_limit = s2_dec_ff.lim;
      rsp_in.dpl = s2_dec_ff.acc[6:5];
      rsp_in.current_cpl = priv_in;
      if (s2_dec_ff.calc_en) begin
         if (s2_dec_ff.exdown) begin
            rsp_in.offset_low = s2_dec_ff.gran ? lim_inc_page : {11'd0, lim_inc};
            rsp_in.offset_high = 32'hffff_ffff;
         end else begin
            rsp_in.offset_low = 32'd0;
            rsp_in.offset_high = s2_dec_ff.gran ? {s2_dec_ff.lim, 12'hfff} :
                                                  {12'd0, s2_dec_ff.lim};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         priv_ff <= 2'd0;
      end else if (s3_rdy) begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            priv_ff <= priv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault == FAULT_NONE |-> rsp_data.error_code == 16'd0)
      else $error("error code set without a fault");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.fault == FAULT_GP || rsp_data.fault == FAULT_NP ||
                    rsp_data.fault == FAULT_SS)
      |-> !rsp_data.write_access_back && rsp_data.offset_high == 32'd0 &&
          rsp_data.seg_base == 32'd0)
      else $error("aborted load returned descriptor fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_access_back |-> rsp_data.access_byte[AccAccessed] &&
                                                  rsp_data.access_byte[AccPresent])
      else $error("write-back without accessed and present bits");

   assert property (@(posedge clock) disable iff (reset)
      s3_rdy && s2_valid_ff |=> priv_ff == rsp_data.current_cpl)
      else $error("privilege level and reported level disagree");
`endif

endmodule

// File: verif/segment_descriptor_loader_test.sv
module segment_descriptor_loader_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sdl_pkg::*;

   localparam int unsigned QuietLimit = 1000;
   localparam int unsigned RandomPhases = 5;
   localparam int unsigned LoadsPerPhase = 155;

   localparam logic [7:0] AccDataRw = 8'h92;
   localparam logic [7:0] AccDataDown = 8'h96;
   localparam logic [7:0] AccCodeRx = 8'h9a;
   localparam logic [7:0] AccCodeXo = 8'h98;
   localparam logic [7:0] AccSystem = 8'h89;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   logic [31:0] gdt_base_m;
   logic [15:0] gdt_limit_m;
   logic [31:0] ldt_base_m;
   logic [19:0] ldt_limit_m;
   logic prot_mode_m;
   logic [1:0] cpl_m;

   rsp_type pending_loads[$];
   int unsigned mismatches = 0;
   int unsigned responses_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned sink_hold_cycles = 0;
   bit gaps_off = 1'b0;

   segment_descriptor_loader i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] make_descriptor(input logic [31:0] base,
                                                   input logic [19:0] lim,
                                                   input logic [7:0] acc,
                                                   input logic [3:0] flg);
      return {base[31:24], flg, lim[19:16], acc, base[23:0], lim[15:0]};
   endfunction

   function automatic rsp_type predict_segment_load(input req_type item);
      rsp_type r;
      logic [15:0] sel;
      logic [15:0] body;
      logic [31:0] tbl_base;
      logic [31:0] tbl_limit;
      logic [7:0] acc;
      logic [3:0] flg;
      logic [31:0] base;
      logic [19:0] lim;
      logic [31:0] lim32;
      logic [31:0] lmin;
      logic [31:0] lmax;
      logic [2:0] fault;
      logic wb;
      logic abort;
      logic gran;
      r = '0;
      sel = item.selector;
      body = sel & 16'hfff8;
      tbl_base = sel[2] ? ldt_base_m : gdt_base_m;
      tbl_limit = sel[2] ? {12'b0, ldt_limit_m} : {16'b0, gdt_limit_m};
      acc = '0;
      flg = '0;
      base = '0;
      lim = '0;
      lmin = '0;
      lmax = '0;
      fault = FAULT_NONE;
      wb = 1'b0;
      abort = 1'b0;
      if ({16'b0, body} + 32'd7 > tbl_limit) begin
         fault = FAULT_GP;
         abort = 1'b1;
      end else begin
         if (sel >= 16'd4) begin
            lim = {item.descriptor[51:48], item.descriptor[15:0]};
            base = {item.descriptor[63:56], item.descriptor[39:16]};
            acc = item.descriptor[47:40];
            flg = item.descriptor[55:52];
            if (acc[AccCodeData] && acc[AccPresent] && !acc[AccAccessed]) begin
               acc[AccAccessed] = 1'b1;
               wb = 1'b1;
            end
         end
         lim32 = {12'b0, lim};
         gran = flg[FlgGran];
         if (item.action == ACTION_DATA || item.action == ACTION_STACK) begin
            if (item.action == ACTION_DATA && sel >= 16'd4 && !acc[AccPresent]) begin
               fault = FAULT_NP;
               abort = 1'b1;
            end else if (item.action == ACTION_STACK && !acc[AccPresent]) begin
               fault = FAULT_SS;
               abort = 1'b1;
            end else if (acc[AccExDown]) begin
               lmin = gran ? ((lim32 + 32'd1) << 12) : lim32 + 32'd1;
               lmax = 32'hffff_ffff;
            end else begin
               lmax = gran ? {lim, 12'hfff} : lim32;
            end
         end else if (item.action == ACTION_CODE) begin
            if (!acc[AccPresent] || !acc[AccCodeData] || !acc[AccExec] ||
                !acc[AccReadable]) begin
               fault = FAULT_UNKNOWN;
            end
            lmax = gran ? {lim, 12'hfff} : lim32;
            if (prot_mode_m) begin
               cpl_m = sel[1:0];
            end
         end
      end
      r.fault = fault;
      r.error_code = (fault != FAULT_NONE) ? (sel & 16'hfffc) : 16'h0000;
      r.table_address = tbl_base + {16'b0, body};
      if (!abort) begin
         r.write_access_back = wb;
         r.access_byte = acc;
         r.flags_nibble = flg;
         r.seg_base = base;
         r.raw_limit = lim;
         r.offset_low = lmin;
         r.offset_high = lmax;
         r.dpl = acc[6:5];
      end
      r.current_cpl = cpl_m;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("response %0d: %s is 0x%h, expected 0x%h", responses_seen, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic check_segment_load(input rsp_type got, input rsp_type want);
      check_field("fault", 32'(got.fault), 32'(want.fault));
      check_field("error_code", 32'(got.error_code), 32'(want.error_code));
      check_field("table_address", got.table_address, want.table_address);
      check_field("write_access_back", 32'(got.write_access_back),
                  32'(want.write_access_back));
      check_field("access_byte", 32'(got.access_byte), 32'(want.access_byte));
      check_field("flags_nibble", 32'(got.flags_nibble), 32'(want.flags_nibble));
      check_field("seg_base", got.seg_base, want.seg_base);
      check_field("raw_limit", 32'(got.raw_limit), 32'(want.raw_limit));
      check_field("offset_low", got.offset_low, want.offset_low);
      check_field("offset_high", got.offset_high, want.offset_high);
      check_field("dpl", 32'(got.dpl), 32'(want.dpl));
      check_field("current_cpl", 32'(got.current_cpl), 32'(want.current_cpl));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_loads.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.table_address, 32'h0);
         end else begin
            check_segment_load(rsp_data, pending_loads.pop_front());
         end
         responses_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
         $display("segment_descriptor_loader_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : response_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         stall = gaps_off ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_valid);
      end
   end

   task automatic send_load(input req_type item);
      int unsigned gap;
      gap = gaps_off ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_loads.push_back(predict_segment_load(item));
   endtask

   task automatic send_directed(input logic [1:0] action, input logic [15:0] sel,
                                input logic [63:0] desc);
      req_type item;
      item.action = action;
      item.selector = sel;
      item.descriptor = desc;
      send_load(item);
   endtask

   task automatic drain_loads();
      req_valid <= 1'b0;
      while (pending_loads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_GDT_BASE: gdt_base_m = value;
         CSR_GDT_LIMIT: gdt_limit_m = value[15:0];
         CSR_LDT_BASE: ldt_base_m = value;
         CSR_LDT_LIMIT: ldt_limit_m = value[19:0];
         CSR_PROT_NOT_V86: prot_mode_m = value[0];
         default: ;
      endcase
   endtask

   task automatic configure_tables(input logic [31:0] gdt_base, input logic [15:0] gdt_limit,
                                   input logic [31:0] ldt_base, input logic [19:0] ldt_limit,
                                   input logic prot_mode);
      write_register(CSR_GDT_BASE, gdt_base);
      write_register(CSR_GDT_LIMIT, {16'b0, gdt_limit});
      write_register(CSR_LDT_BASE, ldt_base);
      write_register(CSR_LDT_LIMIT, {12'b0, ldt_limit});
      write_register(CSR_PROT_NOT_V86, {31'b0, prot_mode});
   endtask

   function automatic int unsigned pick_limit(input int unsigned max_value);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return 0;
      end else if (pick == 1) begin
         return 7;
      end else if (pick < 4) begin
         return max_value;
      end
      return $urandom_range(7, max_value);
   endfunction

   function automatic req_type make_random_load();
      req_type item;
      int unsigned pick;
      int unsigned tbl_limit;
      int unsigned max_index;
      logic [31:0] low_word;
      logic [31:0] high_word;
      logic [7:0] acc;
      item.action = 2'($urandom_range(0, 3));
      item.selector = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         item.selector[15:2] = '0;
      end else if (pick < 85) begin
         tbl_limit = item.selector[2] ? 32'(ldt_limit_m) : 32'(gdt_limit_m);
         if (tbl_limit >= 7) begin
            max_index = (tbl_limit - 7) / 8;
            if (max_index > 8191) begin
               max_index = 8191;
            end
            item.selector[15:3] = 13'($urandom_range(0, max_index));
         end
      end
      low_word = $urandom;
      high_word = $urandom;
      item.descriptor = {high_word, low_word};
      acc = 8'($urandom);
      acc[AccPresent] = ($urandom_range(0, 3) != 0);
      acc[AccCodeData] = ($urandom_range(0, 3) != 0);
      if (item.action == ACTION_CODE && $urandom_range(0, 1) == 1) begin
         acc[AccExec] = 1'b1;
         acc[AccReadable] = 1'b1;
      end
      item.descriptor[47:40] = acc;
      if ($urandom_range(0, 7) == 0) begin
         item.descriptor[15:0] = 16'hffff;
         item.descriptor[51:48] = 4'hf;
      end
      return item;
   endfunction

   task automatic test_reset_state();
      send_directed(ACTION_DATA, 16'h0000, 64'h0);
      send_directed(ACTION_CODE, 16'hffff, {64{1'b1}});
      send_directed(ACTION_STACK, 16'h0004, make_descriptor(32'h0, 20'h0, AccDataRw, 4'h0));
      drain_loads();
   endtask

   task automatic test_table_limits();
      configure_tables(32'h0000_8000, 16'h000f, 32'hffff_fff8, 20'h00007, 1'b0);
      send_directed(ACTION_DATA, 16'h0008,
                    make_descriptor(32'h1234_5678, 20'h0ffff, AccDataRw, 4'h4));
      send_directed(ACTION_DATA, 16'h0010,
                    make_descriptor(32'h1234_5678, 20'h0ffff, AccDataRw, 4'h4));
      send_directed(ACTION_CODE, 16'h000f,
                    make_descriptor(32'h0, 20'hfffff, AccCodeRx, 4'hc));
      send_directed(ACTION_STACK, 16'h0007,
                    make_descriptor(32'hdead_beef, 20'h00100, AccDataRw, 4'h0));
      send_directed(ACTION_RAW, 16'h0003, {64{1'b1}});
      send_directed(ACTION_CODE, 16'h0005,
                    make_descriptor(32'h0040_0000, 20'h00fff, AccCodeRx, 4'h8));
      drain_loads();
   endtask

   task automatic test_descriptor_decode();
      configure_tables(32'hffff_fff0, 16'hffff, 32'h0000_1000, 20'hfffff, 1'b1);
      send_directed(ACTION_RAW, 16'h0000, {64{1'b1}});
      send_directed(ACTION_DATA, 16'h0003, {64{1'b1}});
      send_directed(ACTION_STACK, 16'h0001, {64{1'b1}});
      send_directed(ACTION_CODE, 16'h0002, {64{1'b1}});
      send_directed(ACTION_DATA, 16'hfff8,
                    make_descriptor(32'hffff_ffff, 20'h00000, AccDataRw, 4'h0));
      send_directed(ACTION_DATA, 16'h0010,
                    make_descriptor(32'h0, 20'hfffff, AccDataDown, 4'h8));
      send_directed(ACTION_DATA, 16'h0018,
                    make_descriptor(32'h0001_0000, 20'h00010, AccDataDown | 8'h01, 4'h4));
      send_directed(ACTION_DATA, 16'h0020,
                    make_descriptor(32'h0, 20'h00fff, AccDataRw & 8'h7f, 4'h0));
      send_directed(ACTION_STACK, 16'h0028,
                    make_descriptor(32'h0, 20'h00fff, AccDataRw & 8'h7f, 4'h0));
      send_directed(ACTION_STACK, 16'h0030,
                    make_descriptor(32'h8000_0000, 20'hfffff, AccDataRw, 4'hc));
      send_directed(ACTION_CODE, 16'h003b,
                    make_descriptor(32'h0, 20'hfffff, AccCodeRx | 8'h60, 4'hc));
      send_directed(ACTION_CODE, 16'h0041,
                    make_descriptor(32'h0, 20'h0abcd, AccCodeXo, 4'h0));
      send_directed(ACTION_CODE, 16'h0048,
                    make_descriptor(32'h0, 20'h0abcd, AccSystem, 4'h8));
      send_directed(ACTION_RAW, 16'h0050,
                    make_descriptor(32'h5555_aaaa, 20'h5a5a5, 8'h13, 4'hf));
      send_directed(ACTION_RAW, 16'h0058,
                    make_descriptor(32'haaaa_5555, 20'ha5a5a, AccSystem, 4'h0));
      send_directed(ACTION_CODE, 16'hffff, {64{1'b1}});
      send_directed(ACTION_DATA, 16'h0008, 64'h0);
      drain_loads();
   endtask

   task automatic test_backpressure();
      int unsigned n;
      gaps_off = 1'b1;
      sink_hold_cycles = 60;
      for (n = 0; n < 48; n++) begin
         send_load(make_random_load());
      end
      drain_loads();
      gaps_off = 1'b0;
   endtask

   task automatic test_random_loads();
      int unsigned phase;
      int unsigned n;
      for (phase = 0; phase < RandomPhases; phase++) begin
         if (phase == 0) begin
            configure_tables(32'hffff_ffff, 16'hffff, 32'h0, 20'hfffff, 1'b1);
         end else begin
            configure_tables($urandom, 16'(pick_limit(32'hffff)), $urandom,
                             20'(pick_limit(32'hfffff)), 1'($urandom_range(0, 1)));
         end
         gaps_off = (phase == 2);
         for (n = 0; n < LoadsPerPhase; n++) begin
            send_load(make_random_load());
         end
         drain_loads();
      end
      gaps_off = 1'b0;
   endtask

   initial begin
      gdt_base_m = '0;
      gdt_limit_m = '0;
      ldt_base_m = '0;
      ldt_limit_m = '0;
      prot_mode_m = 1'b0;
      cpl_m = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_table_limits();
      test_descriptor_decode();
      test_backpressure();
      test_random_loads();
      drain_loads();
      repeat (8) @(posedge clock);
      if (pending_loads.size() != 0) begin
         report_mismatch("transactions never returned", pending_loads.size(), 32'h0);
      end
      if (mismatches == 0) begin
         $display("segment_descriptor_loader_test: done, clean");
      end else begin
         $display("segment_descriptor_loader_test: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/sdl_pkg.sv
hw/rtl/sdl_decode.sv
hw/rtl/segment_descriptor_loader.sv
verif/segment_descriptor_loader_test.sv
